// ===== design/tmut_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmut_pkg
// Shared types and constants of the tick to microsecond timer.
// ----------------------------------------------------------------------------
package tmut_pkg;

   localparam int TMUT_WORD_W = 64;
   localparam int TMUT_DIV_W  = 16;
   localparam int TMUT_CNT_W  = 6;
   localparam int TMUT_ADDR_W = 3;

   // register index, taken from address bit 2
   localparam logic TMUT_REG_TICK_RATE = 1'b0;

   typedef struct packed {
      logic start;
      logic step;
   } tmut_ctl_type;

endpackage
`default_nettype wire

// ===== design/tmut_serial_adder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmut_serial_adder
// Bit-serial adder / subtractor, least significant bit first.
// ----------------------------------------------------------------------------
module tmut_serial_adder
   import tmut_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tmut_ctl_type ctl,
   input  wire logic         sub,
   input  wire logic         a_bit,
   input  wire logic         b_bit,
   output logic              sum_bit
);

   logic carry_ff;
   logic carry_in;
   logic cin;
   logic b_eff;

   always_comb begin
      cin      = ctl.start ? sub : carry_ff;
      b_eff    = b_bit ^ sub;
      sum_bit  = a_bit ^ b_eff ^ cin;
      carry_in = (a_bit & b_eff) | (a_bit & cin) | (b_eff & cin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 1'b0;
      end else if (ctl.step) begin
         carry_ff <= carry_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/tmut_serial_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmut_serial_divider
// Restoring divider, one dividend bit in and one quotient bit out per cycle while step is high.
// ----------------------------------------------------------------------------
module tmut_serial_divider
   import tmut_pkg::*;
(
   input  wire logic                  clock,
   input  wire tmut_ctl_type          ctl,
   input  wire logic [TMUT_DIV_W-1:0] divisor,
   input  wire logic                  din,
   output logic                       q_bit
);

   logic [TMUT_DIV_W-1:0] rem_ff;
   logic [TMUT_DIV_W-1:0] rem_in;
   logic [TMUT_DIV_W-1:0] rem_base;
   logic [TMUT_DIV_W:0]   trial;
   logic [TMUT_DIV_W:0]   diff;

   always_comb begin
      rem_base = ctl.start ? '0 : rem_ff;
      trial    = {rem_base, din};
      diff     = trial - {1'b0, divisor};
      q_bit    = (trial >= {1'b0, divisor});
      rem_in   = q_bit ? diff[TMUT_DIV_W-1:0] : trial[TMUT_DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         rem_ff <= rem_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/tick_to_microsecond_monotonic_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tick_to_microsecond_monotonic_timer
// Converts 64-bit tick counter samples into a wrapping microsecond total.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. After the request transfer it goes
// through bit-serial subtraction for the tick difference, restoring division
// by the tick rate register (one quotient bit a cycle), bit-serial addition
// into the total and result hand-over; no new sample is taken before that
// hand-over. req_stall is high while a sample is in work, and stays high for
// as long as a finished result waits for the output register to free up. A
// tick rate of zero counts as one.
module tick_to_microsecond_monotonic_timer
   import tmut_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [63:0]            req_current_tick,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [63:0]                 rsp_elapsed_usecs,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [TMUT_ADDR_W-1:0] paddr,
   input  wire logic [31:0]            pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_DIV,
      ST_ADD,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [TMUT_CNT_W-1:0]  count_ff, count_in;
   logic                   started_ff, started_in;
   logic                   qnz_ff, qnz_in;
   logic [TMUT_WORD_W-1:0] now_ff, now_in;
   logic [TMUT_WORD_W-1:0] ref_ff, ref_in;
   logic [TMUT_WORD_W-1:0] work_ff, work_in;
   logic [TMUT_WORD_W-1:0] total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TMUT_WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [TMUT_DIV_W-1:0]  tpu_ff, tpu_in;

   logic [TMUT_DIV_W-1:0]  divisor;
   tmut_ctl_type           add_ctl;
   tmut_ctl_type           div_ctl;
   logic                   add_sub;
   logic                   add_a;
   logic                   add_b;
   logic                   add_sum;
   logic                   q_bit;
   logic                   last;
   logic                   req_xfer;
   logic                   csr_write;

   assign req_stall         = (state_ff != ST_IDLE);
   assign req_xfer          = req_valid & ~req_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elapsed_usecs = rsp_data_ff;
   assign pready            = 1'b1;
   assign prdata            = (paddr[2] == TMUT_REG_TICK_RATE) ?
                              {{(32-TMUT_DIV_W){1'b0}}, tpu_ff} : '0;
   assign csr_write         = psel & penable & pwrite & pready;
   assign divisor           = (tpu_ff == '0) ? {{(TMUT_DIV_W-1){1'b0}}, 1'b1} : tpu_ff;
   assign last              = (count_ff == {TMUT_CNT_W{1'b1}});

   tmut_serial_adder u_adder (
      .clock   (clock),
      .reset   (reset),
      .ctl     (add_ctl),
      .sub     (add_sub),
      .a_bit   (add_a),
      .b_bit   (add_b),
      .sum_bit (add_sum)
   );

   tmut_serial_divider u_divider (
      .clock   (clock),
      .ctl     (div_ctl),
      .divisor (divisor),
      .din     (work_ff[TMUT_WORD_W-1]),
      .q_bit   (q_bit)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      started_in   = started_ff;
      qnz_in       = qnz_ff;
      now_in       = now_ff;
      ref_in       = ref_ff;
      work_in      = work_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      tpu_in       = tpu_ff;

      add_ctl.start = (count_ff == '0);
      add_ctl.step  = (state_ff == ST_SUB) || (state_ff == ST_ADD);
      div_ctl.start = (count_ff == '0);
      div_ctl.step  = (state_ff == ST_DIV);
      add_sub       = (state_ff == ST_SUB);
      add_a         = (state_ff == ST_SUB) ? now_ff[0] : total_ff[0];
      add_b         = (state_ff == ST_SUB) ? ref_ff[0] : work_ff[0];

      if (csr_write && (paddr[2] == TMUT_REG_TICK_RATE)) begin
         tpu_in = pwdata[TMUT_DIV_W-1:0];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff != ST_IDLE && state_ff != ST_DONE) begin
         count_in = count_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               now_in   = req_current_tick;
               qnz_in   = 1'b0;
               count_in = '0;
               state_in = ST_SUB;
               if (!started_ff) begin
                  ref_in     = req_current_tick;
                  started_in = 1'b1;
               end
            end
         end
         ST_SUB: begin
            // difference formed lsb first, both operands rotate back in place
            now_in  = {now_ff[0], now_ff[TMUT_WORD_W-1:1]};
            ref_in  = {ref_ff[0], ref_ff[TMUT_WORD_W-1:1]};
            work_in = {add_sum, work_ff[TMUT_WORD_W-1:1]};
            if (last) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            work_in = {work_ff[TMUT_WORD_W-2:0], q_bit};
            qnz_in  = qnz_ff | q_bit;
            if (last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            total_in = {add_sum, total_ff[TMUT_WORD_W-1:1]};
            work_in  = {1'b0, work_ff[TMUT_WORD_W-1:1]};
            if (last) begin
               state_in = ST_DONE;
               if (qnz_ff) begin
                  ref_in = now_ff;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         started_ff   <= 1'b0;
         qnz_ff       <= 1'b0;
         ref_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tpu_ff       <= {{(TMUT_DIV_W-1){1'b0}}, 1'b1};
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         started_ff   <= started_in;
         qnz_ff       <= qnz_in;
         ref_ff       <= ref_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         tpu_ff       <= tpu_in;
      end
      now_ff      <= now_in;
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   // an accepted transfer starts the subtraction
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_SUB) && (count_ff == '0))
      else $error("accepted transfer did not start subtraction");

   // bit counter is at zero whenever no phase runs
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff == '0))
      else $error("bit counter not cleared in idle");

   // total stays zero until the first sample
   a_total_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (total_ff == '0))
      else $error("total moved before first sample");

   // addition phase ends in result hand-over
   a_add_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) && last |=> (state_ff == ST_DONE))
      else $error("addition phase did not end in hand-over");

endmodule
`default_nettype wire
